// ===== design/eam_pkg.sv =====
// Shared types, constants and codes for the environment alarm monitor.
`default_nettype none

package eam_pkg;

   localparam int AVG_SAMPLES_DEFAULT = 4;

   localparam int BYTE_W      = 8;
   localparam int LIMIT_W     = 7;
   localparam int DUST_LIM_W  = 10;
   localparam int DUST_W      = 9;
   localparam int LEVEL_W     = 8;
   localparam int QUO_W       = 9;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 10;

   localparam int ADC_FULL    = 255;
   localparam int ADC_SPAN    = 256;
   localparam int DUST_SCALE  = 500;
   localparam int FAN_SCALE   = 200;
   localparam int FULL_SCALE  = 500;

   localparam logic [LIMIT_W-1:0]    TEMP_LOW_RESET  = 7'd20;
   localparam logic [LIMIT_W-1:0]    TEMP_HIGH_RESET = 7'd35;
   localparam logic [LIMIT_W-1:0]    HUMI_LOW_RESET  = 7'd40;
   localparam logic [LIMIT_W-1:0]    HUMI_HIGH_RESET = 7'd85;
   localparam logic [DUST_LIM_W-1:0] DUST_LIM_RESET  = 10'd200;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TEMP_LOW  = 3'd0,
      REG_TEMP_HIGH = 3'd1,
      REG_HUMI_LOW  = 3'd2,
      REG_HUMI_HIGH = 3'd3,
      REG_DUST_LIM  = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DUST_START,
      ST_DUST_RUN,
      ST_FAN_START,
      ST_FAN_RUN,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] adc_sample;
      logic [BYTE_W-1:0] humi_int_byte;
      logic [BYTE_W-1:0] humi_frac_byte;
      logic [BYTE_W-1:0] temp_int_byte;
      logic [BYTE_W-1:0] temp_frac_byte;
      logic [BYTE_W-1:0] check_byte;
   } req_data_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  temp_value;
      logic [BYTE_W-1:0]  humi_value;
      logic [DUST_W-1:0]  dust_value;
      logic               frame_ok;
      logic               temp_over;
      logic               temp_under;
      logic               humi_over;
      logic               humi_under;
      logic               dust_over;
      logic               buzzer_on;
      logic               fan_run;
      logic [LEVEL_W-1:0] fan_level;
   } rsp_data_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== design/eam_div.sv =====
// Bit-serial restoring divider producing one quotient bit per cycle.
`default_nettype none

module eam_div
   import eam_pkg::*;
#(
   parameter int ACC_W = 22,
   parameter int DEN_W = 11
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [ACC_W-1:0]  dividend,
   input  wire logic [DEN_W-1:0]  divisor,
   output div_status_type         status,
   output logic [QUO_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [ACC_W-1:0] rem_ff, rem_in;
   logic [ACC_W-1:0] dsh_ff, dsh_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             fits;

   assign fits = rem_ff >= dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dsh_in  = ACC_W'(divisor) << (QUO_W - 1);
         quo_in  = '0;
         cnt_in  = CNT_W'(QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_ff - dsh_ff : rem_ff;
         dsh_in = dsh_ff >> 1;
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

`default_nettype wire

// ===== design/environment_alarm_monitor_unit.sv =====
// Top level of the environment alarm monitor: averaging, frame check, alarms and fan drive.
//
// Each transaction on the req_ channel is one monitor cycle: a dust ADC sample and a
// five-byte humidity and temperature frame. Each one yields exactly one transaction on
// the rsp_ channel carrying the current readings, the frame status, the alarms and the
// fan drive. The limits are written through the csr_ port, register by register; the user
// must do so while no transaction is in progress, as the block itself does not enforce it.
// When the transaction neither completes a dust average nor raises the dust alarm, the
// result register is loaded from the output state, after the fan start state. A shared
// bit-serial divider adds a pass: a start, nine quotient bits, then the quotient is taken.
// There is one pass for the dust average on the sample that completes an average, and
// one for the fan level while the dust alarm is set.
// The block takes one transaction at a time and is ready again in the cycle after the result
// register is loaded, so it accepts no new transaction before the last one is through.
// A finished result waits in the output register; a new transaction is accepted while
// it waits, and the next result is held back, with req_ready low, until the receiver
// has taken the old one.
// Reset restores the default limits and clears the averaging sum, the sample count,
// the dust reading, temperature and humidity, and empties the output register.
`default_nettype none

module environment_alarm_monitor_unit
   import eam_pkg::*;
#(
   parameter int AVG_SAMPLES = AVG_SAMPLES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_data_type          req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_data_type               rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SUM_W    = $clog2(ADC_FULL * AVG_SAMPLES + 1);
   localparam int CNT_W    = $clog2(AVG_SAMPLES + 1);
   localparam int DUST_DIV = ADC_SPAN * AVG_SAMPLES;
   localparam int NUM_A_W  = $clog2(ADC_FULL * AVG_SAMPLES * DUST_SCALE + 1);
   localparam int NUM_B_W  = $clog2(FAN_SCALE * FULL_SCALE + 1);
   localparam int NUM_W    = (NUM_A_W > NUM_B_W) ? NUM_A_W : NUM_B_W;
   localparam int DEN_A_W  = $clog2(DUST_DIV + 1);
   localparam int DEN_B_W  = $clog2(FULL_SCALE + 1);
   localparam int DEN_W    = (DEN_A_W > DEN_B_W) ? DEN_A_W : DEN_B_W;
   localparam int ACC_W    = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   state_type state_ff, state_in;

   logic [LIMIT_W-1:0]    temp_low_ff, temp_high_ff, humi_low_ff, humi_high_ff;
   logic [DUST_LIM_W-1:0] dust_lim_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DUST_W-1:0]     dust_ff;
   logic [BYTE_W-1:0]     temp_ff, humi_ff;
   logic                  rsp_valid_ff;
   rsp_data_type          rsp_ff;
   logic                  ok_ff;
   logic [ACC_W-1:0]      dust_num_ff;
   logic [LEVEL_W-1:0]    level_ff;

   logic                  accept;
   logic                  wrap;
   logic [SUM_W-1:0]      sum_in;
   logic [CNT_W-1:0]      cnt_in;
   logic [BYTE_W-1:0]     frame_sum;
   logic                  frame_ok;
   logic                  d_over;
   logic [DUST_W-1:0]     dust_diff;
   logic [DUST_LIM_W-1:0] fan_den;
   logic                  div_start;
   logic [ACC_W-1:0]      div_dividend;
   logic [DEN_W-1:0]      div_divisor;
   div_status_type        div_status;
   logic [QUO_W-1:0]      div_quotient;
   logic                  out_load;
   logic                  t_over, t_under, h_over, h_under;

   assign accept    = req_valid && req_ready;
   assign sum_in    = sum_ff + SUM_W'(req_data.adc_sample);
   assign cnt_in    = cnt_ff + CNT_W'(1);
   assign wrap      = cnt_in == CNT_W'(AVG_SAMPLES);
   assign frame_sum = req_data.humi_int_byte + req_data.humi_frac_byte
                    + req_data.temp_int_byte + req_data.temp_frac_byte;
   assign frame_ok  = frame_sum == req_data.check_byte;

   assign d_over    = {1'b0, dust_ff} > dust_lim_ff;
   assign dust_diff = DUST_W'({1'b0, dust_ff} - dust_lim_ff);
   assign fan_den   = DUST_LIM_W'(FULL_SCALE) - dust_lim_ff;

   assign t_over  = temp_ff > {1'b0, temp_high_ff};
   assign t_under = !t_over && (temp_ff < {1'b0, temp_low_ff});
   assign h_over  = humi_ff > {1'b0, humi_high_ff};
   assign h_under = !h_over && (humi_ff < {1'b0, humi_low_ff});

   eam_div #(
      .ACC_W (ACC_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = wrap ? ST_DUST_START : ST_FAN_START;
            end
         end
         ST_DUST_START: state_in = ST_DUST_RUN;
         ST_DUST_RUN: begin
            if (div_status.done) begin
               state_in = ST_FAN_START;
            end
         end
         ST_FAN_START: state_in = d_over ? ST_FAN_RUN : ST_OUTPUT;
         ST_FAN_RUN: begin
            if (div_status.done) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      div_start    = 1'b0;
      out_load     = 1'b0;
      div_dividend = dust_num_ff;
      div_divisor  = DEN_W'(DUST_DIV);
      unique case (state_ff)
         ST_IDLE:       req_ready = 1'b1;
         ST_DUST_START: div_start = 1'b1;
         ST_FAN_START: begin
            div_start    = d_over;
            div_dividend = ACC_W'(dust_diff) * ACC_W'(FAN_SCALE);
            div_divisor  = DEN_W'(fan_den);
         end
         ST_OUTPUT:     out_load = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         temp_low_ff  <= TEMP_LOW_RESET;
         temp_high_ff <= TEMP_HIGH_RESET;
         humi_low_ff  <= HUMI_LOW_RESET;
         humi_high_ff <= HUMI_HIGH_RESET;
         dust_lim_ff  <= DUST_LIM_RESET;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         dust_ff      <= '0;
         temp_ff      <= '0;
         humi_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_TEMP_LOW:  temp_low_ff  <= csr_wdata[LIMIT_W-1:0];
               REG_TEMP_HIGH: temp_high_ff <= csr_wdata[LIMIT_W-1:0];
               REG_HUMI_LOW:  humi_low_ff  <= csr_wdata[LIMIT_W-1:0];
               REG_HUMI_HIGH: humi_high_ff <= csr_wdata[LIMIT_W-1:0];
               REG_DUST_LIM:  dust_lim_ff  <= csr_wdata[DUST_LIM_W-1:0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            sum_ff <= wrap ? '0 : sum_in;
            cnt_ff <= wrap ? '0 : cnt_in;
            if (frame_ok) begin
               temp_ff <= req_data.temp_int_byte;
               humi_ff <= req_data.humi_int_byte;
            end
         end
         if (state_ff == ST_DUST_RUN && div_status.done) begin
            dust_ff <= DUST_W'(div_quotient);
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff       <= frame_ok;
         dust_num_ff <= ACC_W'(sum_in) * ACC_W'(DUST_SCALE);
      end
      if (state_ff == ST_FAN_START && !d_over) begin
         level_ff <= '0;
      end else if (state_ff == ST_FAN_RUN && div_status.done) begin
         level_ff <= LEVEL_W'(div_quotient);
      end
      if (out_load) begin
         rsp_ff.temp_value <= temp_ff;
         rsp_ff.humi_value <= humi_ff;
         rsp_ff.dust_value <= dust_ff;
         rsp_ff.frame_ok   <= ok_ff;
         rsp_ff.temp_over  <= t_over;
         rsp_ff.temp_under <= t_under;
         rsp_ff.humi_over  <= h_over;
         rsp_ff.humi_under <= h_under;
         rsp_ff.dust_over  <= d_over;
         rsp_ff.buzzer_on  <= t_over || t_under || h_over || h_under || d_over;
         rsp_ff.fan_run    <= d_over;
         rsp_ff.fan_level  <= level_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the environment alarm monitor unit.
module tb
   import eam_pkg::*;
();

   localparam int HOLD_CYCLES     = 400;
   localparam int SETTLE_CYCLES   = 25;
   localparam int DRAIN_LIMIT     = 2000;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 205;
   localparam int UNMAPPED_FIRST  = REG_DUST_LIM + 1;
   localparam int INDEX_TOP       = (1 << CSR_IDX_W) - 1;

   class alarm_scoreboard;
      logic [LIMIT_W-1:0]    temp_low, temp_high, humi_low, humi_high;
      logic [DUST_LIM_W-1:0] dust_lim;
      int unsigned           adc_sum, sample_count;
      logic [DUST_W-1:0]     dust;
      logic [BYTE_W-1:0]     temp, humi;
      rsp_data_type          expected_q[$];
      int unsigned           errors, checked, frames_ok, frames_bad, dust_alarms;

      function new();
         temp_low     = TEMP_LOW_RESET;
         temp_high    = TEMP_HIGH_RESET;
         humi_low     = HUMI_LOW_RESET;
         humi_high    = HUMI_HIGH_RESET;
         dust_lim     = DUST_LIM_RESET;
         adc_sum      = 0;
         sample_count = 0;
         dust         = '0;
         temp         = '0;
         humi         = '0;
         errors       = 0;
         checked      = 0;
         frames_ok    = 0;
         frames_bad   = 0;
         dust_alarms  = 0;
      endfunction

      function void write_register(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_TEMP_LOW:  temp_low  = val[LIMIT_W-1:0];
            REG_TEMP_HIGH: temp_high = val[LIMIT_W-1:0];
            REG_HUMI_LOW:  humi_low  = val[LIMIT_W-1:0];
            REG_HUMI_HIGH: humi_high = val[LIMIT_W-1:0];
            REG_DUST_LIM:  dust_lim  = val[DUST_LIM_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(input req_data_type d);
         rsp_data_type      e;
         logic [BYTE_W-1:0] frame_sum;
         int unsigned       excess;
         adc_sum += d.adc_sample;
         sample_count++;
         if (sample_count >= AVG_SAMPLES_DEFAULT) begin
            dust         = DUST_W'((adc_sum * DUST_SCALE) / (ADC_SPAN * AVG_SAMPLES_DEFAULT));
            adc_sum      = 0;
            sample_count = 0;
         end
         frame_sum  = d.humi_int_byte + d.humi_frac_byte + d.temp_int_byte + d.temp_frac_byte;
         e.frame_ok = (frame_sum == d.check_byte);
         if (e.frame_ok) begin
            temp = d.temp_int_byte;
            humi = d.humi_int_byte;
            frames_ok++;
         end else begin
            frames_bad++;
         end
         e.temp_value = temp;
         e.humi_value = humi;
         e.dust_value = dust;
         e.temp_over  = temp > temp_high;
         e.temp_under = !e.temp_over && (temp < temp_low);
         e.humi_over  = humi > humi_high;
         e.humi_under = !e.humi_over && (humi < humi_low);
         e.dust_over  = dust > dust_lim;
         e.fan_run    = e.dust_over;
         e.buzzer_on  = e.temp_over || e.temp_under || e.humi_over || e.humi_under
                        || e.dust_over;
         e.fan_level  = '0;
         if (e.dust_over) begin
            excess      = int'(dust) - int'(dust_lim);
            e.fan_level = LEVEL_W'((FAN_SCALE * excess) / (FULL_SCALE - int'(dust_lim)));
         end
         expected_q.push_back(e);
      endfunction

      task report(input string msg);
         $display("ERROR: %s", msg);
         errors++;
      endtask

      task compare(input string field, input logic [15:0] got, input logic [15:0] want);
         if (got !== want)
            report($sformatf("result %0d: %s is %0d, expected %0d", checked, field, got, want));
      endtask

      task check_response(input rsp_data_type got);
         rsp_data_type want;
         if (expected_q.size() == 0) begin
            report("result transaction arrived with no expectation waiting");
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (want.dust_over) dust_alarms++;
         compare("temp_value", got.temp_value, want.temp_value);
         compare("humi_value", got.humi_value, want.humi_value);
         compare("dust_value", got.dust_value, want.dust_value);
         compare("frame_ok", got.frame_ok, want.frame_ok);
         compare("temp_over", got.temp_over, want.temp_over);
         compare("temp_under", got.temp_under, want.temp_under);
         compare("humi_over", got.humi_over, want.humi_over);
         compare("humi_under", got.humi_under, want.humi_under);
         compare("dust_over", got.dust_over, want.dust_over);
         compare("buzzer_on", got.buzzer_on, want.buzzer_on);
         compare("fan_run", got.fan_run, want.fan_run);
         compare("fan_level", got.fan_level, want.fan_level);
      endtask

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_data_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_data_type          rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   alarm_scoreboard sb;
   int          send_idle_pct = 0;
   int          rsp_idle_pct  = 0;
   int unsigned items_sent    = 0;
   int unsigned adc_style     = 0;
   int unsigned settings_used = 1;
   int unsigned drain_cycles  = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_seen    = 0;
   int unsigned hold_left     = 0;

   environment_alarm_monitor_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         hold_left  <= 0;
         holds_seen <= 0;
      end else if (hold_requests != holds_seen) begin
         holds_seen <= hold_requests;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if (req_valid && req_ready) sb.note_request(req_data);
      end
   end

   function automatic req_data_type make_frame(input logic [BYTE_W-1:0] adc, hi, hf, ti, tf,
                                               input bit good);
      req_data_type      d;
      logic [BYTE_W-1:0] sum;
      d.adc_sample     = adc;
      d.humi_int_byte  = hi;
      d.humi_frac_byte = hf;
      d.temp_int_byte  = ti;
      d.temp_frac_byte = tf;
      sum              = hi + hf + ti + tf;
      d.check_byte     = good ? sum : sum ^ (BYTE_W'(1) << $urandom_range(BYTE_W - 1));
      return d;
   endfunction

   function automatic logic [BYTE_W-1:0] near_limit(input int unsigned lim);
      int v;
      v = int'(lim) + int'($urandom_range(4)) - 2;
      if (v < 0) v = 0;
      if (v > ADC_FULL) v = ADC_FULL;
      return BYTE_W'(v);
   endfunction

   function automatic logic [BYTE_W-1:0] pick_reading(input int unsigned lo_lim, hi_lim);
      case ($urandom_range(2))
         0: return near_limit(lo_lim);
         1: return near_limit(hi_lim);
         default: return BYTE_W'($urandom);
      endcase
   endfunction

   function automatic req_data_type random_item();
      logic [BYTE_W-1:0] adc;
      req_data_type      d;
      case (adc_style)
         0: adc = BYTE_W'($urandom_range(ADC_FULL, 170));
         1: adc = BYTE_W'($urandom_range(60, 0));
         2: adc = ($urandom_range(1) != 0) ? BYTE_W'(ADC_FULL) : '0;
         default: adc = BYTE_W'($urandom);
      endcase
      d = make_frame(adc, pick_reading(sb.humi_low, sb.humi_high), BYTE_W'($urandom),
                     pick_reading(sb.temp_low, sb.temp_high), BYTE_W'($urandom),
                     $urandom_range(99) < 80);
      if ($urandom_range(19) == 0) d.check_byte = BYTE_W'($urandom);
      return d;
   endfunction

   task automatic send_item(input req_data_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic idle_sender();
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_register(idx, val);
   endtask

   task automatic program_limits(input logic [CSR_DATA_W-1:0] tl, th, hl, hh, dl);
      write_reg(REG_TEMP_LOW, tl);
      write_reg(REG_TEMP_HIGH, th);
      write_reg(REG_HUMI_LOW, hl);
      write_reg(REG_HUMI_HIGH, hh);
      write_reg(REG_DUST_LIM, dl);
      // A write beyond the register map must leave every limit untouched.
      write_reg(CSR_IDX_W'($urandom_range(INDEX_TOP, UNMAPPED_FIRST)), CSR_DATA_W'($urandom));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(make_frame(255, 0, 0, 0, 0, 1));
      send_item(make_frame(255, 255, 255, 255, 255, 1));
      send_item(make_frame(255, 255, 255, 255, 255, 0));
      send_item(make_frame(255, 86, 0, 36, 0, 1));
      send_item(make_frame(0, 85, 0, 35, 0, 1));
      send_item(make_frame(0, 39, 128, 19, 127, 1));
      send_item(make_frame(0, 40, 0, 20, 0, 1));
      send_item(make_frame(0, 170, 85, 85, 170, 0));
      send_item(make_frame(128, 60, 0, 25, 0, 1));
      send_item(make_frame(128, 0, 255, 255, 0, 1));
      send_item(make_frame(128, 8'hAA, 8'h55, 8'h55, 8'hAA, 1));
      send_item(make_frame(128, 1, 2, 3, 4, 0));
      send_item(make_frame(255, 99, 200, 98, 100, 1));
      send_item(make_frame(0, 100, 255, 100, 255, 0));
      send_item(make_frame(255, 128, 64, 127, 63, 1));
      send_item(make_frame(0, 50, 7, 30, 9, 1));

      for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
         wait_for_results();
         repeat (SETTLE_CYCLES) @(posedge clock);
         case (phase)
            1: program_limits(0, 99, 0, 99, 0);
            2: program_limits(99, 0, 99, 0, 497);
            3: program_limits(10'h3FF, 120, 100, 10'h380, 498);
            4: program_limits(CSR_DATA_W'($urandom_range(99)), CSR_DATA_W'($urandom_range(99)),
                              CSR_DATA_W'($urandom_range(99)), CSR_DATA_W'($urandom_range(99)),
                              CSR_DATA_W'($urandom_range(999, 1)));
            5: program_limits(25, 30, 45, 70, 10'h3FF);
            default: program_limits(CSR_DATA_W'($urandom_range(99)),
                                    CSR_DATA_W'($urandom_range(99)),
                                    CSR_DATA_W'($urandom_range(99)),
                                    CSR_DATA_W'($urandom_range(99)), 1);
         endcase
         settings_used++;
         if (phase <= 2) begin
            send_idle_pct = 19;
            rsp_idle_pct  <= 71;
         end else if (phase <= 4) begin
            send_idle_pct = 71;
            rsp_idle_pct  <= 19;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  <= 0;
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (items_sent % AVG_SAMPLES_DEFAULT == 0) adc_style = $urandom_range(3);
            send_item(random_item());
            if (phase == 1 && n == 0)
               hold_requests <= hold_requests + 1;
            else if (phase == 4 && n == ITEMS_PER_PHASE / 2)
               wait_for_results();
            else
               idle_sender();
         end
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected result transactions never arrived", sb.pending()));

      $display("Covered %0d transactions under %0d limit settings: %0d frames accepted, %0d %s",
               items_sent, settings_used, sb.frames_ok, sb.frames_bad, "rejected.");
      $display("Dust alarm on %0d results, with one long receiver hold-off and one sender pause.",
               sb.dust_alarms);
      if (sb.errors == 0)
         $display("environment_alarm_monitor_unit: match");
      else
         $display("environment_alarm_monitor_unit: mismatch");
      $finish;
   end

   initial begin
      #4000000;
      $display("environment_alarm_monitor_unit: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
design/eam_pkg.sv
design/eam_div.sv
design/environment_alarm_monitor_unit.sv
tb/tb.sv
